@@ rtl/tdlw_pkg.sv @@
// tdlw_pkg: shared types, codes and record helpers for the tile display list walker.
// No dependencies; used by the interfaces, input stage, walker, output queue, top level and testbench.
`default_nettype none

package tdlw_pkg;

	localparam int ADDR_BITS = 23;
	localparam int WORD_BITS = 32;
	localparam int MAX_RES   = 3;

	typedef logic [ADDR_BITS-1:0] addr_t;

	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_WORD  = 1'b1;

	// top three bits of an object list word
	localparam logic [2:0] TOP_TRI_ARRAY  = 3'b100;
	localparam logic [2:0] TOP_QUAD_ARRAY = 3'b101;
	localparam logic [2:0] TOP_LINK       = 3'b111;

	typedef enum logic [3:0] {
		KIND_FETCH  = 4'd0,
		KIND_REGION = 4'd1,
		KIND_LIST   = 4'd2,
		KIND_STRIP  = 4'd3,
		KIND_TRI    = 4'd4,
		KIND_QUAD   = 4'd5,
		KIND_LINK   = 4'd6,
		KIND_END    = 4'd7,
		KIND_DONE   = 4'd8,
		KIND_ERROR  = 4'd9
	} rec_kind_t;

	typedef struct packed {
		rec_kind_t   rec_kind;
		addr_t       fetch_addr;
		logic [5:0]  tile_x;
		logic [5:0]  tile_y;
		logic [3:0]  region_flags;
		logic [2:0]  list_type;
		logic [20:0] prim_addr;
		logic [2:0]  skip;
		logic        shadow;
		logic [5:0]  mask_or_count;
	} rec_t;

	typedef struct packed {
		logic                 valid;
		logic                 func;
		logic [WORD_BITS-1:0] mem_word;
	} item_t;

	// results of one input item, oldest in slot 0
	typedef struct packed {
		logic [1:0]              cnt;
		rec_t [MAX_RES-1:0]      recs;
	} group_t;

	function automatic rec_t make_rec(rec_kind_t kind, addr_t addr, logic [2:0] ltype);
		rec_t r;
		r            = '0;
		r.rec_kind   = kind;
		r.fetch_addr = addr;
		r.list_type  = ltype;
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/tdlw_ifs.sv @@
// tdlw_ifs: valid/ready channel interfaces for the tile display list walker.
// Item, result and configuration channels; depends on tdlw_pkg for the address type.
`default_nettype none

interface tdlw_item_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [31:0] mem_word;

	modport source (output valid, func, mem_word, input ready);
	modport sink (input valid, func, mem_word, output ready);
endinterface

interface tdlw_result_if;
	logic                valid;
	logic                ready;
	logic [3:0]          rec_kind;
	tdlw_pkg::addr_t     fetch_addr;
	logic [5:0]          tile_x;
	logic [5:0]          tile_y;
	logic [3:0]          region_flags;
	logic [2:0]          list_type;
	logic [20:0]         prim_addr;
	logic [2:0]          skip;
	logic                shadow;
	logic [5:0]          mask_or_count;
	logic                last;

	modport source (output valid, rec_kind, fetch_addr, tile_x, tile_y, region_flags,
		list_type, prim_addr, skip, shadow, mask_or_count, last, input ready);
	modport sink (input valid, rec_kind, fetch_addr, tile_x, tile_y, region_flags,
		list_type, prim_addr, skip, shadow, mask_or_count, last, output ready);
endinterface

interface tdlw_cfg_if;
	logic            valid;
	logic            ready;
	tdlw_pkg::addr_t region_base;

	modport source (output valid, region_base, input ready);
	modport sink (input valid, region_base, output ready);
endinterface

`default_nettype wire

@@ rtl/tile_display_list_walker.sv @@
// tile_display_list_walker: top level of the region array and object list walker.
// Uses tdlw_pkg, tdlw_ifs, tdlw_in_stage, tdlw_walker and tdlw_out_queue.
//
// Usage:
//   item   - func 0 starts a walk at region_base; func 1 carries the memory word
//            read at the address named by the most recent fetch record.
//   result - records (fetch, region, list start, primitives, link, end of list,
//            done, error); last marks the final record caused by one item beat.
//   cfg    - writes region_base; always ready, write it only while idle.
// An item's beat is registered in the input register and decoded combinationally;
// its records are loaded into the result register once that register is free.
// Throughput: one item per cycle while each item yields one record and the
// receiver is ready; an item yielding several records holds the result register
// until its final record is taken, one record per beat, and the input register
// absorbs one more item meanwhile.
// Reset clears the walk state to idle and empties both registers; words
// arriving while idle produce no records. A stalled receiver backs up the
// result register and then the input register, dropping item.ready.
`default_nettype none

module tile_display_list_walker #(
	parameter int NUM_LISTS = 5
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	tdlw_item_if.sink      item,
	tdlw_result_if.source  result,
	tdlw_cfg_if.sink       cfg
);
	import tdlw_pkg::*;

	addr_t  region_base_q;
	item_t  item_s1;
	logic   take;
	logic   grp_free;
	group_t grp;
	rec_t   head;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_base_q <= '0;
		end else if (cfg.valid) begin
			region_base_q <= cfg.region_base;
		end
	end

	tdlw_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.in_func  (item.func),
		.in_word  (item.mem_word),
		.take     (take),
		.item_s1  (item_s1)
	);

	tdlw_walker #(
		.NUM_LISTS (NUM_LISTS)
	) u_walker (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_s1     (item_s1),
		.region_base (region_base_q),
		.grp_free    (grp_free),
		.take        (take),
		.grp         (grp)
	);

	tdlw_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take),
		.grp       (grp),
		.grp_free  (grp_free),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.head      (head),
		.out_last  (result.last)
	);

	assign result.rec_kind      = head.rec_kind;
	assign result.fetch_addr    = head.fetch_addr;
	assign result.tile_x        = head.tile_x;
	assign result.tile_y        = head.tile_y;
	assign result.region_flags  = head.region_flags;
	assign result.list_type     = head.list_type;
	assign result.prim_addr     = head.prim_addr;
	assign result.skip          = head.skip;
	assign result.shadow        = head.shadow;
	assign result.mask_or_count = head.mask_or_count;

endmodule

`default_nettype wire

@@ rtl/tdlw_in_stage.sv @@
// tdlw_in_stage: input register in front of the walker decode.
// Holds one accepted beat until the walker takes it; depends on tdlw_pkg.
`default_nettype none

module tdlw_in_stage (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic            in_func,
	input  wire logic [31:0]     in_word,
	input  wire logic            take,
	output tdlw_pkg::item_t      item_s1
);
	import tdlw_pkg::*;

	logic                 valid_s1;
	logic                 func_s1;
	logic [WORD_BITS-1:0] word_s1;

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1 <= in_func;
			word_s1 <= in_word;
		end
	end

	assign item_s1 = '{valid: valid_s1, func: func_s1, mem_word: word_s1};

endmodule

`default_nettype wire

@@ rtl/tdlw_walker.sv @@
// tdlw_walker: walk state and combinational decode of one registered beat.
// Produces a group of up to three records per beat; depends on tdlw_pkg.
`default_nettype none

module tdlw_walker #(
	parameter int NUM_LISTS = 5
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire tdlw_pkg::item_t item_s1,
	input  wire tdlw_pkg::addr_t region_base,
	input  wire logic            grp_free,
	output logic                 take,
	output tdlw_pkg::group_t     grp
);
	import tdlw_pkg::*;

	localparam int ENTRY_BYTES = 4 * (1 + NUM_LISTS);

	typedef enum logic [1:0] {PH_IDLE, PH_CTRL, PH_PTRS, PH_OBJ} phase_t;

	phase_t             phase_q, phase_d;
	addr_t              region_ptr_q, region_d;
	logic [2:0]         list_idx_q, idx_d;
	addr_t              obj_addr_q, obj_d;
	logic               last_region_q, last_d;
	logic [ADDR_BITS:0] list_q [NUM_LISTS];
	logic               list_we;

	logic [WORD_BITS-1:0] w;
	logic [2:0]           top;
	logic [ADDR_BITS:0]   new_ptr;
	logic [ADDR_BITS:0]   eff;
	logic [3:0]           from_idx;
	logic                 found;
	logic [2:0]           sel_idx;
	addr_t                sel_addr;
	addr_t                region_nxt;
	rec_t                 nl_r0, nl_r1;
	logic [1:0]           nl_cnt;
	phase_t               nl_phase;
	addr_t                nl_region;
	logic [2:0]           nl_idx;
	addr_t                nl_obj;
	rec_t                 prim_r;
	rec_kind_t            prim_kind;
	logic [ADDR_BITS:0]   target;
	logic [ADDR_BITS:0]   obj_next;

	function automatic logic region_fits(addr_t a);
		logic [ADDR_BITS:0] s;
		s = {1'b0, a} + (ADDR_BITS+1)'(ENTRY_BYTES);
		return !s[ADDR_BITS];
	endfunction

	// a 4-byte read must end below the top of memory
	function automatic logic obj_fits(logic [ADDR_BITS:0] a);
		logic [ADDR_BITS+1:0] s;
		s = {1'b0, a} + (ADDR_BITS+2)'(4);
		return s[ADDR_BITS+1:ADDR_BITS] == 2'b00;
	endfunction

	assign take = item_s1.valid && grp_free;

	always_comb begin
		w   = item_s1.mem_word;
		top = w[31:29];
		// empty bit over a pointer saturated to the highest address
		new_ptr = {w[31], (|w[30:ADDR_BITS]) ? {ADDR_BITS{1'b1}}
			: {w[ADDR_BITS-1:3], 1'b0, w[1:0]}};

		// search for the next non-empty list, the pointer being written bypassed
		from_idx = (phase_q == PH_PTRS) ? 4'd0 : {1'b0, list_idx_q} + 4'd1;
		found    = 1'b0;
		sel_idx  = '0;
		sel_addr = '0;
		eff      = '0;
		for (int i = 0; i < NUM_LISTS; i++) begin
			eff = (phase_q == PH_PTRS && list_idx_q == 3'(i)) ? new_ptr : list_q[i];
			if (!found && 4'(i) >= from_idx && !eff[ADDR_BITS]) begin
				found    = 1'b1;
				sel_idx  = 3'(i);
				sel_addr = eff[ADDR_BITS-1:0];
			end
		end

		region_nxt = region_ptr_q + ADDR_BITS'(ENTRY_BYTES);

		nl_r0     = '0;
		nl_r1     = '0;
		nl_cnt    = 2'd1;
		nl_phase  = PH_IDLE;
		nl_region = region_ptr_q;
		nl_idx    = list_idx_q;
		nl_obj    = obj_addr_q;
		if (found) begin
			nl_r0  = make_rec(KIND_LIST, sel_addr, sel_idx);
			nl_cnt = 2'd2;
			nl_idx = sel_idx;
			nl_obj = sel_addr;
			if (obj_fits({1'b0, sel_addr})) begin
				nl_r1    = make_rec(KIND_FETCH, sel_addr, sel_idx);
				nl_phase = PH_OBJ;
			end else begin
				nl_r1 = make_rec(KIND_ERROR, sel_addr, 3'd0);
			end
		end else if (last_region_q) begin
			nl_r0 = make_rec(KIND_DONE, '0, 3'd0);
		end else begin
			nl_region = region_nxt;
			if (region_fits(region_nxt)) begin
				nl_r0    = make_rec(KIND_FETCH, region_nxt, 3'd0);
				nl_phase = PH_CTRL;
			end else begin
				nl_r0 = make_rec(KIND_ERROR, region_nxt, 3'd0);
			end
		end

		prim_kind = !w[31] ? KIND_STRIP : ((top == TOP_TRI_ARRAY) ? KIND_TRI : KIND_QUAD);
		prim_r               = make_rec(prim_kind, obj_addr_q, list_idx_q);
		prim_r.prim_addr     = w[20:0];
		prim_r.skip          = w[23:21];
		prim_r.shadow        = w[24];
		prim_r.mask_or_count = !w[31] ? w[30:25] : ({2'b00, w[28:25]} + 6'd1);
		obj_next             = {1'b0, obj_addr_q} + (ADDR_BITS+1)'(4);
		target               = {w[ADDR_BITS:2], 2'b00};

		grp      = '0;
		phase_d  = phase_q;
		region_d = region_ptr_q;
		idx_d    = list_idx_q;
		obj_d    = obj_addr_q;
		last_d   = last_region_q;
		list_we  = 1'b0;

		if (item_s1.func == FUNC_START) begin
			region_d = region_base;
			last_d   = 1'b0;
			idx_d    = '0;
			grp.cnt  = 2'd1;
			if (region_fits(region_base)) begin
				grp.recs[0] = make_rec(KIND_FETCH, region_base, 3'd0);
				phase_d     = PH_CTRL;
			end else begin
				grp.recs[0] = make_rec(KIND_ERROR, region_base, 3'd0);
				phase_d     = PH_IDLE;
			end
		end else begin
			case (phase_q)
				PH_CTRL: begin
					grp.cnt                  = 2'd2;
					grp.recs[0]              = make_rec(KIND_REGION, region_ptr_q, 3'd0);
					grp.recs[0].tile_x       = w[7:2];
					grp.recs[0].tile_y       = w[13:8];
					grp.recs[0].region_flags = w[31:28];
					grp.recs[1] = make_rec(KIND_FETCH, region_ptr_q + ADDR_BITS'(4), 3'd0);
					last_d      = w[31];
					idx_d       = '0;
					phase_d     = PH_PTRS;
				end
				PH_PTRS: begin
					list_we = 1'b1;
					if ({1'b0, list_idx_q} + 4'd1 < 4'(NUM_LISTS)) begin
						idx_d       = list_idx_q + 3'd1;
						grp.cnt     = 2'd1;
						grp.recs[0] = make_rec(KIND_FETCH, region_ptr_q
							+ ADDR_BITS'({1'b0, list_idx_q, 2'b00} + 6'd8), 3'd0);
					end else begin
						grp.cnt     = nl_cnt;
						grp.recs[0] = nl_r0;
						grp.recs[1] = nl_r1;
						phase_d     = nl_phase;
						region_d    = nl_region;
						idx_d       = nl_idx;
						obj_d       = nl_obj;
					end
				end
				PH_OBJ: begin
					if (!w[31] || top == TOP_TRI_ARRAY || top == TOP_QUAD_ARRAY) begin
						grp.cnt     = 2'd2;
						grp.recs[0] = prim_r;
						obj_d       = obj_next[ADDR_BITS-1:0];
						if (obj_fits(obj_next)) begin
							grp.recs[1] = make_rec(KIND_FETCH, obj_next[ADDR_BITS-1:0], list_idx_q);
						end else begin
							grp.recs[1] = make_rec(KIND_ERROR, obj_next[ADDR_BITS-1:0], 3'd0);
							phase_d     = PH_IDLE;
						end
					end else if (top == TOP_LINK) begin
						if (w[28]) begin
							// end of list, then on to the next list, the next region, done or an error
							grp.cnt     = nl_cnt + 2'd1;
							grp.recs[0] = make_rec(KIND_END, target[ADDR_BITS-1:0], list_idx_q);
							grp.recs[1] = nl_r0;
							grp.recs[2] = nl_r1;
							phase_d     = nl_phase;
							region_d    = nl_region;
							idx_d       = nl_idx;
							obj_d       = nl_obj;
						end else begin
							grp.cnt     = 2'd2;
							grp.recs[0] = make_rec(KIND_LINK, target[ADDR_BITS-1:0], list_idx_q);
							obj_d       = target[ADDR_BITS-1:0];
							if (obj_fits(target)) begin
								grp.recs[1] = make_rec(KIND_FETCH, target[ADDR_BITS-1:0], list_idx_q);
							end else begin
								grp.recs[1] = make_rec(KIND_ERROR, target[ADDR_BITS-1:0], 3'd0);
								phase_d     = PH_IDLE;
							end
						end
					end else begin
						grp.cnt     = 2'd1;
						grp.recs[0] = make_rec(KIND_ERROR, obj_addr_q, 3'd0);
						phase_d     = PH_IDLE;
					end
				end
				default: begin
					// word while idle: dropped
					grp.cnt = 2'd0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			region_ptr_q  <= '0;
			list_idx_q    <= '0;
			obj_addr_q    <= '0;
			last_region_q <= 1'b0;
		end else if (take) begin
			phase_q       <= phase_d;
			region_ptr_q  <= region_d;
			list_idx_q    <= idx_d;
			obj_addr_q    <= obj_d;
			last_region_q <= last_d;
		end
	end

	for (genvar i = 0; i < NUM_LISTS; i++) begin : g_list
		always_ff @(posedge clk) begin
			if (take && list_we && list_idx_q == 3'(i)) begin
				list_q[i] <= new_ptr;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/tdlw_out_queue.sv @@
// tdlw_out_queue: result register holding one group of up to three records.
// Sends them one beat at a time and marks the final one; depends on tdlw_pkg.
`default_nettype none

module tdlw_out_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire tdlw_pkg::group_t grp,
	output logic                  grp_free,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output tdlw_pkg::rec_t        head,
	output logic                  out_last
);
	import tdlw_pkg::*;

	rec_t       recs_q [MAX_RES];
	logic [1:0] cnt_q;

	assign out_valid = cnt_q != 2'd0;
	assign out_last  = cnt_q == 2'd1;
	assign head      = recs_q[0];
	// free when empty or when the final beat leaves this cycle
	assign grp_free  = !out_valid || (out_last && out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= grp.cnt;
		end else if (out_valid && out_ready) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < MAX_RES; i++) begin
				recs_q[i] <= grp.recs[i];
			end
		end else if (out_valid && out_ready) begin
			for (int i = 0; i < MAX_RES - 1; i++) begin
				recs_q[i] <= recs_q[i+1];
			end
		end
	end

endmodule

`default_nettype wire

@@ tb/tdlw_walk_checker.sv @@
`timescale 1ns / 1ps
// tdlw_walk_checker: scoreboard for the tile display list walker. Follows the walk from
// accepted item beats and compares each result beat with the oldest predicted record.
// Depends on tdlw_pkg and the channel interfaces in tdlw_ifs.

module tdlw_walk_checker #(
	parameter int NUM_LISTS = 5
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	tdlw_item_if        item,
	tdlw_result_if      result,
	tdlw_cfg_if         cfg,
	output int unsigned pending,
	output int unsigned mismatches
);
	import tdlw_pkg::*;

	localparam longint unsigned MEM_BYTES   = 64'd1 << ADDR_BITS;
	localparam longint unsigned ENTRY_BYTES = 64'd4 * (1 + NUM_LISTS);
	localparam logic [31:0]     PTR_MASK    = 32'h7fff_fffb;

	typedef enum logic [1:0] {WALK_IDLE, WALK_CTRL, WALK_PTRS, WALK_OBJ} walk_phase_t;

	typedef struct packed {
		rec_t rec;
		logic last;
	} rec_beat_t;

	addr_t           base_reg;
	walk_phase_t     phase;
	longint unsigned entry_addr;
	logic            list_empty [NUM_LISTS];
	longint unsigned list_addr [NUM_LISTS];
	int unsigned     cur_list;
	longint unsigned obj_addr;
	logic            final_region;
	rec_t            step_recs[$];
	rec_beat_t       expected_records[$];
	int unsigned     beat_count;

	function automatic rec_t blank_rec(rec_kind_t kind, longint unsigned addr,
			int unsigned ltype);
		rec_t r;
		r            = '0;
		r.rec_kind   = kind;
		r.fetch_addr = addr[ADDR_BITS-1:0];
		r.list_type  = ltype[2:0];
		return r;
	endfunction

	function automatic void walk_error(longint unsigned addr);
		step_recs.push_back(blank_rec(KIND_ERROR, addr, 0));
		phase = WALK_IDLE;
	endfunction

	// a whole entry must fit below the top of memory
	function automatic void open_region();
		if (entry_addr + ENTRY_BYTES >= MEM_BYTES) begin
			walk_error(entry_addr);
		end else begin
			step_recs.push_back(blank_rec(KIND_FETCH, entry_addr, 0));
			phase = WALK_CTRL;
		end
	endfunction

	function automatic void request_object();
		if (obj_addr + 4 >= MEM_BYTES)
			walk_error(obj_addr);
		else
			step_recs.push_back(blank_rec(KIND_FETCH, obj_addr, cur_list));
	endfunction

	function automatic void seek_list(int unsigned from);
		for (int unsigned i = from; i < NUM_LISTS; i++) begin
			if (!list_empty[i]) begin
				cur_list = i;
				obj_addr = list_addr[i];
				step_recs.push_back(blank_rec(KIND_LIST, obj_addr, i));
				phase = WALK_OBJ;
				request_object();
				return;
			end
		end
		if (final_region) begin
			step_recs.push_back(blank_rec(KIND_DONE, 0, 0));
			phase = WALK_IDLE;
		end else begin
			entry_addr += ENTRY_BYTES;
			open_region();
		end
	endfunction

	function automatic void decode_object(logic [31:0] w);
		rec_kind_t       kind;
		rec_t            r;
		longint unsigned target;
		target = {w[23:2], 2'b00};
		if (!w[31] || w[31:29] == TOP_TRI_ARRAY || w[31:29] == TOP_QUAD_ARRAY) begin
			if (!w[31])
				kind = KIND_STRIP;
			else if (w[31:29] == TOP_TRI_ARRAY)
				kind = KIND_TRI;
			else
				kind = KIND_QUAD;
			r           = blank_rec(kind, obj_addr, cur_list);
			r.prim_addr = w[20:0];
			r.skip      = w[23:21];
			r.shadow    = w[24];
			r.mask_or_count = (kind == KIND_STRIP) ? w[30:25] : {2'b00, w[28:25]} + 6'd1;
			step_recs.push_back(r);
			obj_addr += 4;
			request_object();
		end else if (w[31:29] == TOP_LINK) begin
			// only a link word with bit 28 set closes the list
			if (w[28]) begin
				step_recs.push_back(blank_rec(KIND_END, target, cur_list));
				seek_list(cur_list + 1);
			end else begin
				step_recs.push_back(blank_rec(KIND_LINK, target, cur_list));
				obj_addr = target;
				request_object();
			end
		end else begin
			walk_error(obj_addr);
		end
	endfunction

	function automatic void predict_item(logic func, logic [31:0] w);
		longint unsigned p;
		rec_t            r;
		rec_beat_t       b;
		step_recs.delete();
		if (func == FUNC_START) begin
			entry_addr   = base_reg;
			final_region = 1'b0;
			cur_list     = 0;
			open_region();
		end else begin
			case (phase)
				WALK_CTRL: begin
					r              = blank_rec(KIND_REGION, entry_addr, 0);
					r.tile_x       = w[7:2];
					r.tile_y       = w[13:8];
					r.region_flags = w[31:28];
					step_recs.push_back(r);
					final_region = w[31];
					cur_list     = 0;
					phase        = WALK_PTRS;
					step_recs.push_back(blank_rec(KIND_FETCH, entry_addr + 4, 0));
				end
				WALK_PTRS: begin
					// pointers past memory saturate and fail when their list is reached
					p = w & PTR_MASK;
					if (p > MEM_BYTES - 1)
						p = MEM_BYTES - 1;
					list_empty[cur_list] = w[31];
					list_addr[cur_list]  = p;
					if (cur_list + 1 < NUM_LISTS) begin
						cur_list++;
						step_recs.push_back(blank_rec(KIND_FETCH,
							entry_addr + 4 * (cur_list + 1), 0));
					end else begin
						seek_list(0);
					end
				end
				WALK_OBJ: decode_object(w);
				default: ;
			endcase
		end
		foreach (step_recs[i]) begin
			b.rec  = step_recs[i];
			b.last = (i == step_recs.size() - 1);
			expected_records.push_back(b);
		end
	endfunction

	task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
		mismatches++;
		$display("%0t: result beat %0d %s: got 0x%0h, expected 0x%0h",
			$time, beat_count, field, got, want);
	endtask

	task automatic check_result();
		rec_beat_t want;
		if (expected_records.size() == 0) begin
			report_mismatch("unexpected beat, rec_kind", result.rec_kind, 0);
		end else begin
			want = expected_records.pop_front();
			if (result.rec_kind !== want.rec.rec_kind)
				report_mismatch("rec_kind", result.rec_kind, want.rec.rec_kind);
			if (result.fetch_addr !== want.rec.fetch_addr)
				report_mismatch("fetch_addr", result.fetch_addr, want.rec.fetch_addr);
			if (result.tile_x !== want.rec.tile_x)
				report_mismatch("tile_x", result.tile_x, want.rec.tile_x);
			if (result.tile_y !== want.rec.tile_y)
				report_mismatch("tile_y", result.tile_y, want.rec.tile_y);
			if (result.region_flags !== want.rec.region_flags)
				report_mismatch("region_flags", result.region_flags, want.rec.region_flags);
			if (result.list_type !== want.rec.list_type)
				report_mismatch("list_type", result.list_type, want.rec.list_type);
			if (result.prim_addr !== want.rec.prim_addr)
				report_mismatch("prim_addr", result.prim_addr, want.rec.prim_addr);
			if (result.skip !== want.rec.skip)
				report_mismatch("skip", result.skip, want.rec.skip);
			if (result.shadow !== want.rec.shadow)
				report_mismatch("shadow", result.shadow, want.rec.shadow);
			if (result.mask_or_count !== want.rec.mask_or_count)
				report_mismatch("mask_or_count", result.mask_or_count,
					want.rec.mask_or_count);
			if (result.last !== want.last)
				report_mismatch("last", result.last, want.last);
		end
		beat_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_reg     = '0;
			phase        = WALK_IDLE;
			entry_addr   = 0;
			cur_list     = 0;
			obj_addr     = 0;
			final_region = 1'b0;
			foreach (list_empty[i]) begin
				list_empty[i] = 1'b0;
				list_addr[i]  = 0;
			end
			expected_records.delete();
			pending    = 0;
			mismatches = 0;
			beat_count = 0;
		end else begin
			// a record never leaves in the cycle its item beat is taken
			if (result.valid && result.ready)
				check_result();
			if (cfg.valid && cfg.ready)
				base_reg = cfg.region_base;
			if (item.valid && item.ready)
				predict_item(item.func, item.mem_word);
			pending = expected_records.size();
		end
	end

endmodule

@@ tb/tb_tile_display_list_walker.sv @@
`timescale 1ns / 1ps
// tb_tile_display_list_walker: drives start and memory word beats through region walks,
// writes region_base between phases and gives the verdict from tdlw_walk_checker.
// Depends on tdlw_pkg, tdlw_ifs, the walker RTL and tdlw_walk_checker.

module tb_tile_display_list_walker;
	import tdlw_pkg::*;

	localparam int NUM_LISTS   = 5;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 400;

	// func bit above the memory word
	localparam logic [32:0] DIRECTED [24] = '{
		{FUNC_WORD,  32'hffff_ffff},	// ignored while idle
		{FUNC_START, 32'hffff_ffff},
		{FUNC_WORD,  32'h7000_3ffc},	// tile 63,63, flush presort zclear, not last
		{FUNC_WORD,  32'h0000_1004},	// list 0, bit 2 masked off
		{FUNC_WORD,  32'h8000_0000},	// list 1 empty
		{FUNC_WORD,  32'h0000_2000},	// list 2
		{FUNC_WORD,  32'hffff_ffff},	// list 3 empty
		{FUNC_WORD,  32'h7fff_fffc},	// list 4 past memory, saturated
		{FUNC_WORD,  32'h7fff_ffff},	// strip, all fields high
		{FUNC_WORD,  32'h9fff_ffff},	// triangle array, count 16
		{FUNC_WORD,  32'ha000_0000},	// quad array, count 1
		{FUNC_WORD,  32'he000_3000},	// link to 0x3000
		{FUNC_WORD,  32'hf000_2000},	// end of list, on to list 2
		{FUNC_WORD,  32'hc000_0000},	// bad entry type
		{FUNC_WORD,  32'h1234_5678},	// ignored while idle
		{FUNC_START, 32'h0000_0000},
		{FUNC_WORD,  32'h8000_0000},	// last region
		{FUNC_WORD,  32'h007f_fff4},	// list 0 just below the top of memory
		{FUNC_WORD,  32'h8000_0000},
		{FUNC_WORD,  32'h8000_0000},
		{FUNC_WORD,  32'h8000_0000},
		{FUNC_WORD,  32'h8000_0000},
		{FUNC_WORD,  32'h0000_0000},	// strip, all fields low
		{FUNC_WORD,  32'hf0ff_fffc}	// end of list, walk done
	};

	logic        clk;
	logic        arst_n;
	int          idle_pct;
	int          stall_pct;
	bit          hold_req;
	int unsigned items_sent;
	int unsigned pending;
	int unsigned mismatches;
	int unsigned cycle_count;

	tdlw_item_if   item_ch();
	tdlw_result_if result_ch();
	tdlw_cfg_if    cfg_ch();

	tile_display_list_walker #(.NUM_LISTS(NUM_LISTS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	tdlw_walk_checker #(.NUM_LISTS(NUM_LISTS)) walk_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_ch),
		.result     (result_ch),
		.cfg        (cfg_ch),
		.pending    (pending),
		.mismatches (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin : receiver
		int unsigned hold_left;
		hold_left       = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				result_ch.ready = 1'b0;
				hold_left--;
			end else begin
				result_ch.ready = (int'($urandom_range(99)) >= stall_pct);
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tile_display_list_walker test failed");
		$finish;
	end

	// entered and left at a falling edge
	task automatic send_item(logic func, logic [31:0] word);
		while (int'($urandom_range(99)) < idle_pct) begin
			item_ch.valid = 1'b0;
			@(negedge clk);
		end
		item_ch.valid    = 1'b1;
		item_ch.func     = func;
		item_ch.mem_word = word;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	// occasional junk beat or abandoned walk
	task automatic send_word(logic [31:0] w);
		int unsigned pick;
		pick = $urandom_range(199);
		if (pick == 0)
			send_item(FUNC_START, $urandom);
		if (pick < 10)
			send_item(FUNC_WORD, $urandom);
		else
			send_item(FUNC_WORD, w);
	endtask

	function automatic logic [31:0] pointer_word(bit empty);
		logic [31:0] w;
		int unsigned pick;
		w    = $urandom;
		pick = $urandom_range(99);
		if (pick < 85)
			w[30:23] = '0;
		else if (pick < 92)
			w[30:0] = {8'd0, 18'h3ffff, 5'($urandom_range(31))};
		w[31] = empty;
		return w;
	endfunction

	function automatic logic [31:0] object_word();
		logic [31:0] w;
		int unsigned pick;
		w    = $urandom;
		pick = $urandom_range(99);
		if (pick < 40) begin
			w[31] = 1'b0;
		end else if (pick < 60) begin
			w[31:29] = TOP_TRI_ARRAY;
		end else if (pick < 80) begin
			w[31:29] = TOP_QUAD_ARRAY;
		end else begin
			w[31:29] = TOP_LINK;
			w[28]    = 1'b0;
			// most link targets stay inside memory
			if (pick < 97)
				w[23] = 1'b0;
		end
		return w;
	endfunction

	task automatic walk_scene(int unsigned regions);
		bit          empty [NUM_LISTS];
		logic [31:0] w;
		send_item(FUNC_START, $urandom);
		for (int unsigned r = 0; r < regions; r++) begin
			w     = $urandom;
			w[31] = (r == regions - 1);
			send_word(w);
			for (int l = 0; l < NUM_LISTS; l++) begin
				empty[l] = ($urandom_range(99) < 45);
				send_word(pointer_word(empty[l]));
			end
			for (int l = 0; l < NUM_LISTS; l++) begin
				if (!empty[l]) begin
					repeat ($urandom_range(5))
						send_word(object_word());
					w        = $urandom;
					w[31:28] = {TOP_LINK, 1'b1};
					send_word(w);
				end
			end
		end
	endtask

	task automatic write_base(addr_t base);
		item_ch.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		// words while idle give no record but may still be in flight
		repeat (8) @(negedge clk);
		cfg_ch.valid       = 1'b1;
		cfg_ch.region_base = base;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic run_phase(addr_t base, int s_pct, int r_pct, bit long_hold,
			int unsigned n_items);
		int unsigned goal;
		write_base(base);
		idle_pct  = s_pct;
		stall_pct = r_pct;
		hold_req  = long_hold;
		goal      = items_sent + n_items;
		while (items_sent < goal) begin
			if ($urandom_range(9) == 0)
				repeat (8) send_item(1'($urandom), $urandom);
			else
				walk_scene($urandom_range(1, 3));
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		idle_pct           = 0;
		stall_pct          = 0;
		hold_req           = 1'b0;
		items_sent         = 0;
		item_ch.valid      = 1'b0;
		item_ch.func       = FUNC_START;
		item_ch.mem_word   = '0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.region_base = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (DIRECTED[i])
			send_item(DIRECTED[i][32], DIRECTED[i][31:0]);

		run_phase('0, 0, 0, 1'b1, 60);
		run_phase(addr_t'($urandom_range(32'h7f_0000) & 32'hffff_fffc), 56, 0, 1'b0, 60);
		run_phase(addr_t'($urandom_range(32'h7f_0000) & 32'hffff_fffc), 0, 56, 1'b0, 60);
		// every start runs off the end of memory
		run_phase(23'd8388604, 17, 17, 1'b0, 10);
		// highest base whose first entry still fits
		run_phase(23'h7f_ffe7, 17, 17, 1'b0, 20);
		run_phase(addr_t'($urandom_range(8388604)), 17, 17, 1'b0, 30);
		run_phase(addr_t'($urandom_range(32'h7f_0000) & 32'hffff_fffc), 17, 17, 1'b0, 60);

		item_ch.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatches == 0)
			$display("tile_display_list_walker test passed");
		else
			$display("tile_display_list_walker test failed");
		$finish;
	end

endmodule
